// File: hdl/lfe_pkg.sv
// Shared types and constants for the link frame encoder.
// Used by lfe_sequencer, lfe_out_reg and link_frame_encoder_with_checksum.
package lfe_pkg;

	localparam int          S_TDATA_W    = 48;
	localparam int          M_TDATA_W    = 8;
	localparam logic [15:0] MAX_PAYLOAD  = 16'd512;
	localparam logic [7:0]  HEAD_RESET   = 8'hAB;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_length;
		logic [7:0]  function_code;
		logic [7:0]  destination_address;
		logic [7:0]  source_address;
	} in_item_t;

	typedef struct packed {
		logic       length_error;
		logic       frame_end;
		logic [7:0] out_byte;
	} out_beat_t;

endpackage

// File: hdl/lfe_sequencer.sv
// Input reg + frame sequencer: holds one transaction, emits its frame bytes
// one per cycle unless stalled, tracking checksums, frame state. Uses lfe_pkg.
module lfe_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        head_byte,
	input  logic              s_valid,
	output logic              s_ready,
	input  lfe_pkg::cmd_t     s_cmd,
	input  lfe_pkg::in_item_t s_item,
	input  logic              out_rdy,
	output logic              beat_valid,
	output lfe_pkg::out_beat_t beat
);
	import lfe_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	in_item_t    item_s1;
	logic [2:0]  idx_q;
	logic [7:0]  running_sum_q;
	logic [7:0]  running_add_q;
	logic [15:0] bytes_left_q;
	logic        frame_open_q;

	logic       emit;
	logic       last;
	logic       frame_byte;
	logic       too_long;
	logic       adv;
	logic       done;
	logic [7:0] sum_base;
	logic [7:0] add_base;
	logic [7:0] new_sum;
	logic [7:0] new_add;

	assign too_long = item_s1.payload_length > MAX_PAYLOAD;

	always_comb begin
		emit       = 1'b0;
		last       = 1'b0;
		frame_byte = 1'b0;
		beat       = '0;
		if (cmd_s1 == CMD_START) begin
			if (too_long) begin
				emit              = 1'b1;
				last              = 1'b1;
				beat.frame_end    = 1'b1;
				beat.length_error = 1'b1;
			end else begin
				emit = 1'b1;
				unique case (idx_q)
					3'd0: begin
						beat.out_byte = head_byte;
						frame_byte    = 1'b1;
					end
					3'd1: begin
						beat.out_byte = item_s1.source_address;
						frame_byte    = 1'b1;
					end
					3'd2: begin
						beat.out_byte = item_s1.destination_address;
						frame_byte    = 1'b1;
					end
					3'd3: begin
						beat.out_byte = item_s1.function_code;
						frame_byte    = 1'b1;
					end
					3'd4: begin
						beat.out_byte = item_s1.payload_length[7:0];
						frame_byte    = 1'b1;
					end
					3'd5: begin
						beat.out_byte = item_s1.payload_length[15:8];
						frame_byte    = 1'b1;
						last          = (item_s1.payload_length != 16'd0);
					end
					3'd6: begin
						beat.out_byte = running_sum_q;
					end
					3'd7: begin
						beat.out_byte  = running_add_q;
						beat.frame_end = 1'b1;
						last           = 1'b1;
					end
				endcase
			end
		end else if (!frame_open_q && idx_q == 3'd0) begin
			last = 1'b1;
		end else begin
			emit = 1'b1;
			priority if (idx_q == 3'd0) begin
				beat.out_byte = item_s1.data_byte;
				frame_byte    = 1'b1;
				last          = (bytes_left_q != 16'd1);
			end else if (idx_q == 3'd1) begin
				beat.out_byte = running_sum_q;
			end else begin
				beat.out_byte  = running_add_q;
				beat.frame_end = 1'b1;
				last           = 1'b1;
			end
		end
	end

	// a start transaction opens with fresh sums
	assign sum_base = (cmd_s1 == CMD_START && idx_q == 3'd0) ? 8'd0 : running_sum_q;
	assign add_base = (cmd_s1 == CMD_START && idx_q == 3'd0) ? 8'd0 : running_add_q;
	assign new_sum  = sum_base + beat.out_byte;
	assign new_add  = add_base + new_sum;

	assign adv        = valid_s1 && (!emit || out_rdy);
	assign done       = adv && last;
	assign s_ready    = !valid_s1 || done;
	assign beat_valid = valid_s1 && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			cmd_s1        <= CMD_START;
			idx_q         <= 3'd0;
			running_sum_q <= 8'd0;
			running_add_q <= 8'd0;
			bytes_left_q  <= 16'd0;
			frame_open_q  <= 1'b0;
		end else begin
			if (s_valid && s_ready) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= s_cmd;
				idx_q    <= 3'd0;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 3'd1;
			end

			if (adv) begin
				if (frame_byte) begin
					running_sum_q <= new_sum;
					running_add_q <= new_add;
				end
				if (cmd_s1 == CMD_START) begin
					if (idx_q == 3'd0) begin
						frame_open_q <= 1'b0;
						bytes_left_q <= 16'd0;
					end
					if (!too_long && idx_q == 3'd5 && item_s1.payload_length != 16'd0) begin
						frame_open_q <= 1'b1;
						bytes_left_q <= item_s1.payload_length;
					end
				end else if (frame_open_q && idx_q == 3'd0) begin
					bytes_left_q <= bytes_left_q - 16'd1;
					if (bytes_left_q == 16'd1) begin
						frame_open_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// File: hdl/lfe_out_reg.sv
// Output register for the encoded byte stream; decouples the sequencer from
// master-side backpressure. Uses lfe_pkg.
module lfe_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          beat_valid,
	input  lfe_pkg::out_beat_t            beat,
	output logic                          out_rdy,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast,
	output logic [0:0]                    m_axis_tuser
);
	import lfe_pkg::*;

	out_beat_t beat_q;
	logic      valid_q;

	assign out_rdy = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_rdy) begin
			valid_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && beat_valid) begin
			beat_q <= beat;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = beat_q.out_byte;
	assign m_axis_tlast  = beat_q.frame_end;
	assign m_axis_tuser  = beat_q.length_error;

endmodule

// File: hdl/link_frame_encoder_with_checksum.sv
// Link frame encoder with sum-and-add checksum. A start transaction yields a
// six-byte header (head byte, source, destination, function, length low/high),
// or the full eight-byte frame when the length is zero, or a single error
// byte when the length exceeds 512. Each payload transaction yields its byte,
// plus the two checksum bytes after the last one. The output emits one byte
// per cycle from a register while m_axis_tready is high; the sequencer holds
// the input until the current transaction's last byte moves into the output
// register. Payload transactions with no frame open yield no output bytes.
// Depends on lfe_pkg, lfe_sequencer and lfe_out_reg.
module link_frame_encoder_with_checksum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_byte_we,
	input  logic [7:0]                    head_byte_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] source_address, [15:8] destination_address, [23:16] function_code,
	// [39:24] payload_length, [47:40] data_byte
	input  logic [lfe_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] command
	input  logic [0:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] out_byte
	output logic [lfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// frame_end
	output logic                          m_axis_tlast,
	// [0] length_error
	output logic [0:0]                    m_axis_tuser
);
	import lfe_pkg::*;

	logic      [7:0] head_byte_q;
	logic            out_rdy;
	logic            beat_valid;
	out_beat_t       beat;
	cmd_t            s_cmd;
	in_item_t        s_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_byte_q <= HEAD_RESET;
		end else if (head_byte_we) begin
			head_byte_q <= head_byte_wdata;
		end
	end

	assign s_cmd  = cmd_t'(s_axis_tuser[0]);
	assign s_item = in_item_t'(s_axis_tdata);

	lfe_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_byte  (head_byte_q),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_cmd      (s_cmd),
		.s_item     (s_item),
		.out_rdy    (out_rdy),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	lfe_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_valid    (beat_valid),
		.beat          (beat),
		.out_rdy       (out_rdy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for link_frame_encoder_with_checksum: directed and random frames,
// predicted byte by byte with sum-and-add checksums and compared on the output stream.
// Depends on lfe_pkg and the encoder RTL.
module tb;
	import lfe_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        head_byte_we = 1'b0;
	logic [7:0]  head_byte_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	out_beat_t   expected_bytes[$];
	logic [7:0]  head_reg = HEAD_RESET;
	logic [7:0]  run_sum = '0;
	logic [7:0]  run_add = '0;
	logic [15:0] bytes_left = '0;
	bit          frame_open = 1'b0;
	bit          steady = 1'b0;
	int          useful_items = 0;
	int          errors = 0;
	int          cycles = 0;
	int          hold_cnt = 0;

	link_frame_encoder_with_checksum dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_byte_we    (head_byte_we),
		.head_byte_wdata (head_byte_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.m_axis_tuser    (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// frame predictor
	task automatic emit_frame_byte(logic [7:0] b);
		out_beat_t beat;
		run_sum = run_sum + b;
		run_add = run_add + run_sum;
		beat.out_byte     = b;
		beat.frame_end    = 1'b0;
		beat.length_error = 1'b0;
		expected_bytes.push_back(beat);
	endtask

	task automatic emit_checksum();
		out_beat_t beat;
		beat.out_byte     = run_sum;
		beat.frame_end    = 1'b0;
		beat.length_error = 1'b0;
		expected_bytes.push_back(beat);
		beat.out_byte  = run_add;
		beat.frame_end = 1'b1;
		expected_bytes.push_back(beat);
		frame_open = 1'b0;
		bytes_left = '0;
	endtask

	task automatic encode_item(cmd_t cmd, in_item_t it);
		out_beat_t beat;
		if (cmd == CMD_START) begin
			useful_items++;
			frame_open = 1'b0;
			bytes_left = '0;
			run_sum    = '0;
			run_add    = '0;
			if (it.payload_length > MAX_PAYLOAD) begin
				beat.out_byte     = '0;
				beat.frame_end    = 1'b1;
				beat.length_error = 1'b1;
				expected_bytes.push_back(beat);
			end else begin
				emit_frame_byte(head_reg);
				emit_frame_byte(it.source_address);
				emit_frame_byte(it.destination_address);
				emit_frame_byte(it.function_code);
				emit_frame_byte(it.payload_length[7:0]);
				emit_frame_byte(it.payload_length[15:8]);
				if (it.payload_length == 0) begin
					emit_checksum();
				end else begin
					frame_open = 1'b1;
					bytes_left = it.payload_length;
				end
			end
		end else if (frame_open) begin
			useful_items++;
			emit_frame_byte(it.data_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 0)
				emit_checksum();
		end
	endtask

	task automatic check_beat();
		out_beat_t want;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected transaction, expected none, actual byte %h last %b err %b",
				$time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
			errors++;
		end else begin
			want = expected_bytes.pop_front();
			if (m_axis_tdata !== want.out_byte) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.out_byte, m_axis_tdata);
				errors++;
			end
			if (m_axis_tlast !== want.frame_end) begin
				$display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
					m_axis_tlast);
				errors++;
			end
			if (m_axis_tuser[0] !== want.length_error) begin
				$display("%0t: length_error expected %b actual %b", $time, want.length_error,
					m_axis_tuser[0]);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
			if (hold_cnt > 0) begin
				m_axis_tready <= 1'b0;
				hold_cnt--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_cnt = pick_gap();
			end
		end
	end

	task automatic send_item(cmd_t cmd, in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		encode_item(cmd, it);
	endtask

	task automatic send_start(logic [7:0] src, logic [7:0] dst, logic [7:0] fn,
			logic [15:0] len);
		in_item_t it;
		it.source_address      = src;
		it.destination_address = dst;
		it.function_code       = fn;
		it.payload_length      = len;
		it.data_byte           = 8'($urandom);
		send_item(CMD_START, it);
	endtask

	task automatic send_data(logic [7:0] b);
		in_item_t it;
		it.source_address      = 8'($urandom);
		it.destination_address = 8'($urandom);
		it.function_code       = 8'($urandom);
		it.payload_length      = 16'($urandom);
		it.data_byte           = b;
		send_item(CMD_DATA, it);
	endtask

	task automatic send_payload(int n);
		repeat (n) send_data(8'($urandom));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_head(logic [7:0] v);
		wait_drained();
		head_byte_we    <= 1'b1;
		head_byte_wdata <= v;
		@(posedge clk);
		head_byte_we <= 1'b0;
		head_reg = v;
	endtask

	task automatic test_stray_bytes();
		send_data(8'h00);
		send_data(8'hFF);
	endtask

	task automatic test_default_head();
		send_start(8'h00, 8'h00, 8'h00, 16'd0);
		send_start(8'hFF, 8'hFF, 8'hFF, 16'd0);
	endtask

	task automatic test_short_payloads();
		send_start(8'h12, 8'h34, 8'h56, 16'd1);
		send_data(8'hFF);
		send_start(8'hA5, 8'h5A, 8'h01, 16'd2);
		send_data(8'h00);
		send_data(8'hFF);
	endtask

	task automatic test_length_limits();
		send_start(8'h01, 8'h02, 8'h03, MAX_PAYLOAD + 16'd1);
		send_data(8'h77);
		send_data(8'h88);
		send_start(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
		send_start(8'h10, 8'h20, 8'h30, 16'd4);
		send_data(8'h01);
		send_data(8'h02);
		send_start(8'h10, 8'h20, 8'h30, 16'h8000);
		send_data(8'h03);
	endtask

	task automatic test_restart();
		send_start(8'h0F, 8'hF0, 8'h3C, 16'd5);
		send_data(8'hC3);
		send_data(8'h99);
		send_start(8'h44, 8'h55, 8'h66, 16'd1);
		send_data(8'h80);
	endtask

	task automatic test_max_length();
		steady = 1'b1;
		send_start(8'($urandom), 8'($urandom), 8'($urandom), MAX_PAYLOAD);
		send_payload(8);
		steady = 1'b0;
		send_payload(8);
	endtask

	task automatic test_head_config();
		write_head(8'h00);
		send_start(8'h11, 8'h22, 8'h33, 16'd0);
		write_head(8'hFF);
		send_start(8'h11, 8'h22, 8'h33, 16'd2);
		send_payload(2);
		write_head(8'h5A);
		send_start(8'hEE, 8'hDD, 8'hCC, 16'd0);
	endtask

	task automatic test_pressure();
		send_start(8'($urandom), 8'($urandom), 8'($urandom), 16'd6);
		send_payload(3);
		wait_drained();
		send_payload(3);
		wait_drained();
		send_start(8'($urandom), 8'($urandom), 8'($urandom), 16'd0);
	endtask

	task automatic random_frame();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0)
			steady = !steady;
		if (r < 8) begin
			send_start(8'($urandom), 8'($urandom), 8'($urandom),
				16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)));
			send_payload($urandom_range(0, 2));
		end else if (r < 14) begin
			send_payload($urandom_range(1, 2));
		end else if (r < 22) begin
			len = $urandom_range(3, 10);
			send_start(8'($urandom), 8'($urandom), 8'($urandom), 16'(len));
			send_payload($urandom_range(0, len - 1));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(0, 4);
			else if (r < 95)
				len = $urandom_range(5, 16);
			else
				len = $urandom_range(17, 40);
			send_start(8'($urandom), 8'($urandom), 8'($urandom), 16'(len));
			send_payload(len);
		end
	endtask

	task automatic test_random();
		int goal;
		for (int phase = 0; phase < 3; phase++) begin
			write_head(8'($urandom));
			goal = useful_items + 20;
			while (useful_items < goal)
				random_frame();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stray_bytes();
		test_default_head();
		test_short_payloads();
		test_length_limits();
		test_restart();
		test_max_length();
		test_head_config();
		test_pressure();
		test_random();
		wait_drained();
		if (errors == 0 && expected_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
